/* rtl/pbn_pkg.sv */
// Shared types, format codes and constants of the PCM byte-to-sample normalizer.
package pbn_pkg;

    localparam int FRAC_BITS    = 31;
    localparam int MAX_CHANNELS = 16;
    localparam int CH_W         = 4;
    localparam int CNT_W        = 5;
    localparam int VALUE_W      = 33;
    localparam int RAW_W        = 32;

    localparam logic [1:0] FMT_U8  = 2'd0;
    localparam logic [1:0] FMT_S16 = 2'd1;
    localparam logic [1:0] FMT_S24 = 2'd2;
    localparam logic [1:0] FMT_S32 = 2'd3;

    localparam logic REG_FORMAT = 1'b0;
    localparam logic REG_COUNT  = 1'b1;

    typedef struct packed {
        logic [RAW_W-1:0] raw;
        logic [1:0]       fmt;
        logic [CH_W-1:0]  channel;
    } t_sample;

endpackage

/* rtl/pbn_assemble.sv */
// Byte assembly and channel tagging stage with a registered sample output.
module pbn_assemble
    import pbn_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [1:0]       i_fmt,
    input  logic [CNT_W-1:0] i_count,
    input  logic             i_data_valid,
    output logic             o_data_ready,
    input  logic [7:0]       i_data_byte,
    output logic             o_smp_valid,
    input  logic             i_smp_ready,
    output t_sample          o_smp
);

    logic [1:0]      r_pos,     n_pos;
    logic [23:0]     r_partial, n_partial;
    logic [CH_W-1:0] r_idx,     n_idx;
    logic            r_valid,   n_valid;
    t_sample         r_smp,     n_smp;

    logic             accept;
    logic             done;
    logic [CNT_W-1:0] cnt;
    logic [CH_W-1:0]  tag;
    logic [CNT_W-1:0] tag_inc;

    assign o_data_ready = !r_valid || i_smp_ready;
    assign accept       = i_data_valid && o_data_ready;
    assign done         = !(r_pos < i_fmt);
    assign o_smp_valid  = r_valid;
    assign o_smp        = r_smp;

    always_comb begin
        if (i_count == '0) begin
            cnt = CNT_W'(1);
        end else if (i_count > CNT_W'(MAX_CHANNELS)) begin
            cnt = CNT_W'(MAX_CHANNELS);
        end else begin
            cnt = i_count;
        end
        tag     = ({1'b0, r_idx} < cnt) ? r_idx : '0;
        tag_inc = {1'b0, tag} + CNT_W'(1);
    end

    always_comb begin
        n_pos     = r_pos;
        n_partial = r_partial;
        n_idx     = r_idx;
        n_valid   = r_valid && !i_smp_ready;
        n_smp     = r_smp;
        if (accept) begin
            if (!done) begin
                n_pos = r_pos + 2'd1;
                unique case (r_pos)
                    2'd0:    n_partial[7:0]   = r_partial[7:0]   | i_data_byte;
                    2'd1:    n_partial[15:8]  = r_partial[15:8]  | i_data_byte;
                    default: n_partial[23:16] = r_partial[23:16] | i_data_byte;
                endcase
            end else begin
                n_pos         = '0;
                n_partial     = '0;
                n_idx         = (tag_inc >= cnt) ? '0 : tag_inc[CH_W-1:0];
                n_valid       = 1'b1;
                n_smp.fmt     = i_fmt;
                n_smp.channel = tag;
                unique case (i_fmt)
                    FMT_U8:  n_smp.raw = {24'd0, i_data_byte};
                    FMT_S16: n_smp.raw = {16'd0, i_data_byte, r_partial[7:0]};
                    FMT_S24: n_smp.raw = {8'd0, i_data_byte, r_partial[15:0]};
                    FMT_S32: n_smp.raw = {i_data_byte, r_partial};
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_partial <= '0;
            r_idx     <= '0;
            r_valid   <= 1'b0;
        end else begin
            r_pos     <= n_pos;
            r_partial <= n_partial;
            r_idx     <= n_idx;
            r_valid   <= n_valid;
        end
        r_smp <= n_smp;
    end

endmodule

/* rtl/pbn_normalize.sv */
// Normalization stage mapping a raw sample onto Q1.31 with a registered result.
module pbn_normalize
    import pbn_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_smp_valid,
    output logic               o_smp_ready,
    input  t_sample            i_smp,
    output logic               o_sample_valid,
    input  logic               i_sample_ready,
    output logic [VALUE_W-1:0] o_sample_value,
    output logic [CH_W-1:0]    o_channel
);

    localparam int Q_BITS = FRAC_BITS + 1;
    localparam logic [VALUE_W-1:0] ONE = VALUE_W'(1) << FRAC_BITS;

    logic               r_valid;
    logic [VALUE_W-1:0] r_value, n_value;
    logic [CH_W-1:0]    r_channel;

    logic [RAW_W-1:0] rep;
    logic [RAW_W-1:0] quot;
    logic             full;
    logic [7:0]       a8;
    logic [15:0]      a16;
    logic [23:0]      a24;
    logic [31:0]      a32;

    assign o_smp_ready    = !r_valid || i_sample_ready;
    assign o_sample_valid = r_valid;
    assign o_sample_value = r_value;
    assign o_channel      = r_channel;

    // The quotient a / (2^b - 1) is the b-bit pattern of a repeated without end.
    always_comb begin
        a8  = i_smp.raw[7:0];
        a16 = {~i_smp.raw[15], i_smp.raw[14:0]};
        a24 = {~i_smp.raw[23], i_smp.raw[22:0]};
        a32 = {~i_smp.raw[31], i_smp.raw[30:0]};
        unique case (i_smp.fmt)
            FMT_U8: begin
                rep  = {4{a8}};
                full = &a8;
            end
            FMT_S16: begin
                rep  = {2{a16}};
                full = &a16;
            end
            FMT_S24: begin
                rep  = {a24, a24[23:16]};
                full = &a24;
            end
            FMT_S32: begin
                rep  = a32;
                full = &a32;
            end
        endcase
        quot = rep >> (RAW_W - Q_BITS);
        if (full) begin
            n_value = ONE;
        end else begin
            n_value = {1'b0, quot} - ONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_smp_ready) begin
            r_valid <= i_smp_valid;
        end
        if (o_smp_ready && i_smp_valid) begin
            r_value   <= n_value;
            r_channel <= i_smp.channel;
        end
    end

endmodule

/* rtl/pcm_byte_to_normalized_sample_top.sv */
// Top level of the PCM byte-to-normalized-sample converter with its register port.
//
// Bytes of an interleaved little-endian PCM data chunk enter on the data channel,
// one word per cycle while data ready is high. Every 1, 2, 3 or 4 bytes, as
// sample_format selects, one normalized Q1.31 sample leaves on the sample channel
// with its channel index, registered first in the byte assembly stage and then in
// the normalization stage. Throughput is one byte every cycle while samples are
// taken; each stage holds one registered word and loads when empty or read out.
// When the receiver stalls, the stages fill and then data ready falls; no word
// is lost. Synchronous reset empties both stages, clears the partial sample and
// channel counter, and sets the format to signed 32-bit and the count to two.
// Registers sit on the APB port at byte address 0 (sample_format) and
// 4 (channel_count); pready is always high and writes belong to idle periods.
module pcm_byte_to_normalized_sample_top
    import pbn_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               i_data_valid,
    output logic               o_data_ready,
    input  logic [7:0]         i_data_byte,
    output logic               o_sample_valid,
    input  logic               i_sample_ready,
    output logic [VALUE_W-1:0] o_sample_value,
    output logic [CH_W-1:0]    o_channel
);

    logic [1:0]       r_fmt;
    logic [CNT_W-1:0] r_count;
    logic             smp_valid;
    logic             smp_ready;
    t_sample          smp;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt   <= FMT_S32;
            r_count <= CNT_W'(2);
        end else if (psel && penable && pwrite && pready) begin
            unique case (paddr[2])
                REG_FORMAT: r_fmt   <= pwdata[1:0];
                REG_COUNT:  r_count <= pwdata[CNT_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_FORMAT: prdata = {30'd0, r_fmt};
            REG_COUNT:  prdata = {{(32 - CNT_W){1'b0}}, r_count};
        endcase
    end

    pbn_assemble u_assemble (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fmt        (r_fmt),
        .i_count      (r_count),
        .i_data_valid (i_data_valid),
        .o_data_ready (o_data_ready),
        .i_data_byte  (i_data_byte),
        .o_smp_valid  (smp_valid),
        .i_smp_ready  (smp_ready),
        .o_smp        (smp)
    );

    pbn_normalize u_normalize (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_smp_valid    (smp_valid),
        .o_smp_ready    (smp_ready),
        .i_smp          (smp),
        .o_sample_valid (o_sample_valid),
        .i_sample_ready (i_sample_ready),
        .o_sample_value (o_sample_value),
        .o_channel      (o_channel)
    );

endmodule

/* tb/tb.sv */
// Self-checking testbench for the PCM byte-to-normalized-sample converter.
module tb;
    import pbn_pkg::*;

    localparam int RANDOM_BYTES = 1800;
    localparam int DRAIN_CYCLES = 6;
    localparam int CYCLE_LIMIT  = 200000;

    typedef enum logic [1:0] {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_PERIODIC} t_rx_mode;

    typedef struct {
        logic [VALUE_W-1:0] value;
        logic [CH_W-1:0]    channel;
    } t_expected_sample;

    logic               i_clk          = 1'b0;
    logic               i_rst_n        = 1'b0;
    logic               psel           = 1'b0;
    logic               penable        = 1'b0;
    logic               pwrite         = 1'b0;
    logic [2:0]         paddr          = '0;
    logic [31:0]        pwdata         = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               i_data_valid   = 1'b0;
    logic               o_data_ready;
    logic [7:0]         i_data_byte    = '0;
    logic               o_sample_valid;
    logic               i_sample_ready = 1'b0;
    logic [VALUE_W-1:0] o_sample_value;
    logic [CH_W-1:0]    o_channel;

    logic [1:0]         cfg_format   = FMT_S32;
    logic [CNT_W-1:0]   cfg_count    = 5'd2;
    logic [1:0]         pred_pos     = '0;
    logic [23:0]        pred_partial = '0;
    logic [CH_W-1:0]    pred_channel = '0;

    t_expected_sample   expected_samples[$];
    int                 mismatches  = 0;
    int                 burst_left  = 0;
    int                 cycle_count = 0;
    t_rx_mode           rx_mode     = RX_ALWAYS;
    int                 rx_left     = 0;
    int                 rx_tick     = 0;

    pcm_byte_to_normalized_sample_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .i_data_valid   (i_data_valid),
        .o_data_ready   (o_data_ready),
        .i_data_byte    (i_data_byte),
        .o_sample_valid (o_sample_valid),
        .i_sample_ready (i_sample_ready),
        .o_sample_value (o_sample_value),
        .o_channel      (o_channel)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [VALUE_W-1:0] normalize_sample(logic [31:0] raw, logic [1:0] fmt);
        int          bits;
        logic [63:0] full_range;
        logic [63:0] offset;
        logic [63:0] quotient;
        bits       = 8 * (int'(fmt) + 1);
        full_range = (64'd1 << bits) - 64'd1;
        offset     = {32'd0, raw} & full_range;
        if (fmt != FMT_U8) begin
            offset = offset ^ (64'd1 << (bits - 1));
        end
        if (offset == 64'd0) begin
            return -(VALUE_W'(1) << FRAC_BITS);
        end
        if (offset >= full_range) begin
            return VALUE_W'(1) << FRAC_BITS;
        end
        quotient = (offset << 32) / full_range;
        return quotient[VALUE_W-1:0] - (VALUE_W'(1) << FRAC_BITS);
    endfunction

    function automatic void predict_byte(logic [7:0] b);
        logic [31:0]      raw;
        logic [31:0]      mask;
        int               cnt;
        int               tag;
        t_expected_sample item;
        if (pred_pos < cfg_format) begin
            pred_partial = pred_partial | (24'(b) << (8 * pred_pos));
            pred_pos     = pred_pos + 2'd1;
        end else begin
            mask         = (32'd1 << (8 * cfg_format)) - 32'd1;
            raw          = ({8'd0, pred_partial} & mask) | (32'(b) << (8 * cfg_format));
            pred_partial = '0;
            pred_pos     = '0;
            if (cfg_count == 0) begin
                cnt = 1;
            end else if (cfg_count > MAX_CHANNELS) begin
                cnt = MAX_CHANNELS;
            end else begin
                cnt = int'(cfg_count);
            end
            tag          = (int'(pred_channel) < cnt) ? int'(pred_channel) : 0;
            pred_channel = (tag + 1 >= cnt) ? '0 : CH_W'(tag + 1);
            item.value   = normalize_sample(raw, cfg_format);
            item.channel = CH_W'(tag);
            expected_samples = {expected_samples, item};
        end
    endfunction

    function automatic logic [31:0] extreme_raw(logic [1:0] fmt, bit want_max);
        logic [31:0] min_raw;
        if (fmt == FMT_U8) begin
            return want_max ? 32'hFF : 32'h00;
        end
        min_raw = 32'd1 << (8 * (int'(fmt) + 1) - 1);
        return want_max ? min_raw - 32'd1 : min_raw;
    endfunction

    task automatic report_mismatch(string what, logic [VALUE_W-1:0] got,
                                   logic [VALUE_W-1:0] want);
        $display("mismatch in %s: got %h, expected %h", what, got, want);
        mismatches++;
    endtask

    task automatic send_byte(logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                @(negedge i_clk);
                i_data_valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(64, 200)
                                                     : $urandom_range(1, 24);
        end
        @(negedge i_clk);
        i_data_valid <= 1'b1;
        i_data_byte  <= b;
        @(posedge i_clk);
        while (!o_data_ready) @(posedge i_clk);
        predict_byte(b);
        burst_left--;
    endtask

    task automatic send_sample(logic [31:0] raw, logic [1:0] fmt);
        for (int i = 0; i <= int'(fmt); i++) begin
            send_byte(raw[8*i +: 8]);
        end
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        i_data_valid <= 1'b0;
        burst_left = 0;
        while (expected_samples.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_write(logic reg_sel, logic [31:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_config(logic [1:0] fmt, logic [CNT_W-1:0] count);
        wait_idle();
        apb_write(REG_FORMAT, 32'(fmt));
        cfg_format = fmt;
        apb_write(REG_COUNT, 32'(count));
        cfg_count = count;
    endtask

    task automatic test_reset_defaults();
        send_sample(extreme_raw(FMT_S32, 1'b0), FMT_S32);
        send_sample(extreme_raw(FMT_S32, 1'b1), FMT_S32);
    endtask

    task automatic test_format_extremes(logic [1:0] fmt, logic [CNT_W-1:0] count);
        set_config(fmt, count);
        send_sample(extreme_raw(fmt, 1'b0), fmt);
        send_sample(extreme_raw(fmt, 1'b1), fmt);
        if (fmt == FMT_U8) begin
            send_byte(8'h80);
        end
    endtask

    task automatic test_zero_count();
        set_config(FMT_U8, 5'd0);
        send_byte(8'(($urandom_range(0, 255))));
        send_byte(8'(($urandom_range(0, 255))));
    endtask

    task automatic test_lowered_count();
        set_config(FMT_U8, 5'd16);
        while (pred_channel < 2) send_byte(8'($urandom_range(0, 255)));
        set_config(FMT_U8, 5'd2);
        send_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic test_format_change_mid_sample();
        set_config(FMT_S32, 5'd3);
        repeat (3) send_byte(8'($urandom_range(0, 255)));
        set_config(FMT_S16, 5'd3);
        send_byte(8'($urandom_range(0, 255)));
        set_config(FMT_S24, 5'd3);
        repeat (3) send_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic test_random_stream();
        int               phase;
        int               sent;
        int               n;
        logic [1:0]       fmt;
        logic [CNT_W-1:0] count;
        logic [7:0]       b;
        phase = 0;
        sent  = 0;
        while (sent < RANDOM_BYTES) begin
            fmt = 2'($urandom_range(0, 3));
            case (phase)
                0:       count = 5'd1;
                1:       count = 5'd16;
                2:       count = 5'd31;
                3:       count = 5'd0;
                default: count = CNT_W'($urandom_range(0, 31));
            endcase
            set_config(fmt, count);
            n = $urandom_range(8, 120);
            for (int i = 0; i < n; i++) begin
                if (pred_pos == 0 && $urandom_range(0, 9) == 0) begin
                    send_sample(extreme_raw(fmt, 1'($urandom_range(0, 1))), fmt);
                    sent += int'(fmt) + 1;
                end else begin
                    case ($urandom_range(0, 7))
                        0:       b = 8'h00;
                        1:       b = 8'hFF;
                        2:       b = 8'h80;
                        3:       b = 8'h7F;
                        default: b = 8'($urandom_range(0, 255));
                    endcase
                    send_byte(b);
                    sent++;
                end
            end
            phase++;
        end
    endtask

    always @(negedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode <= t_rx_mode'($urandom_range(0, 3));
            rx_left <= $urandom_range(32, 300);
        end else begin
            rx_left <= rx_left - 1;
        end
        rx_tick <= rx_tick + 1;
        case (rx_mode)
            RX_ALWAYS:   i_sample_ready <= 1'b1;
            RX_COIN:     i_sample_ready <= 1'($urandom_range(0, 1));
            RX_SPARSE:   i_sample_ready <= ($urandom_range(0, 3) == 0);
            RX_PERIODIC: i_sample_ready <= ((rx_tick % 7) < 3);
        endcase
    end

    always @(posedge i_clk) begin : check_samples
        t_expected_sample want;
        if (i_rst_n && o_sample_valid && i_sample_ready) begin
            if (expected_samples.size() == 0) begin
                report_mismatch("unexpected sample", o_sample_value, '0);
            end else begin
                want = expected_samples.pop_front();
                if (o_sample_value !== want.value) begin
                    report_mismatch("sample_value", o_sample_value, want.value);
                end
                if (o_channel !== want.channel) begin
                    report_mismatch("channel", VALUE_W'(o_channel), VALUE_W'(want.channel));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_defaults();
        test_format_extremes(FMT_U8, 5'd1);
        test_format_extremes(FMT_S16, 5'd3);
        test_format_extremes(FMT_S24, 5'd16);
        test_zero_count();
        test_lowered_count();
        test_format_change_mid_sample();
        test_random_stream();
        wait_idle();
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
